// ----- hdl/wdc_pkg.sv -----
package wdc_pkg;

    localparam int FUNC_W     = 3;
    localparam int AMOUNT_W   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int TICK_W     = 16;
    localparam int HOLD_W     = 20;
    localparam int PHASE_W    = 4;

    // worst chain of zero-length phases taken in one item
    localparam int SETTLE_STEPS = 6;

    localparam logic [PHASE_W-1:0] PH_IDLE  = 4'd0;
    localparam logic [PHASE_W-1:0] PH_DIR   = 4'd1;
    localparam logic [PHASE_W-1:0] PH_IHIGH = 4'd2;
    localparam logic [PHASE_W-1:0] PH_ILOW  = 4'd3;
    localparam logic [PHASE_W-1:0] PH_TAIL  = 4'd4;
    localparam logic [PHASE_W-1:0] PH_DESEL = 4'd5;
    localparam logic [PHASE_W-1:0] PH_FINAL = 4'd6;
    localparam logic [PHASE_W-1:0] PH_SSEL  = 4'd7;
    localparam logic [PHASE_W-1:0] PH_SHOLD = 4'd8;

    localparam logic [FUNC_W-1:0] FN_TICK   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_SET    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_UP     = 3'd2;
    localparam logic [FUNC_W-1:0] FN_DOWN   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_STORE  = 3'd4;
    localparam logic [FUNC_W-1:0] FN_PRESET = 3'd5;
    localparam logic [FUNC_W-1:0] FN_HOME   = 3'd6;
    localparam logic [FUNC_W-1:0] FN_NOP    = 3'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_DIR_SETUP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INC_HIGH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INC_LOW      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DESEL_HOLD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STORE_SELECT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STORE_HOLD   = 3'd5;

    localparam logic [TICK_W-1:0] RST_DIR_SETUP    = 16'd3;
    localparam logic [TICK_W-1:0] RST_INC_HIGH     = 16'd2;
    localparam logic [TICK_W-1:0] RST_INC_LOW      = 16'd2;
    localparam logic [TICK_W-1:0] RST_DESEL_HOLD   = 16'd1;
    localparam logic [TICK_W-1:0] RST_STORE_SELECT = 16'd5;
    localparam logic [HOLD_W-1:0] RST_STORE_HOLD   = 20'd20005;

    typedef struct packed {
        logic [TICK_W-1:0] dir_setup;
        logic [TICK_W-1:0] inc_high;
        logic [TICK_W-1:0] inc_low;
        logic [TICK_W-1:0] desel_hold;
        logic [TICK_W-1:0] store_select;
        logic [HOLD_W-1:0] store_hold;
    } t_cfg;

    typedef struct packed {
        logic cs;
        logic ud;
        logic inc;
        logic busy;
        logic rejected;
    } t_pins;

endpackage

// ----- hdl/wdc_cfg.sv -----
module wdc_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_we,
    input  logic [wdc_pkg::CFG_IDX_W-1:0]     i_idx,
    input  logic [wdc_pkg::CFG_DATA_W-1:0]    i_data,
    output wdc_pkg::t_cfg                     o_cfg
);
    import wdc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dir_setup    <= RST_DIR_SETUP;
            r_cfg.inc_high     <= RST_INC_HIGH;
            r_cfg.inc_low      <= RST_INC_LOW;
            r_cfg.desel_hold   <= RST_DESEL_HOLD;
            r_cfg.store_select <= RST_STORE_SELECT;
            r_cfg.store_hold   <= RST_STORE_HOLD;
        end else if (i_we) begin
            unique case (i_idx)
                CFG_DIR_SETUP:    r_cfg.dir_setup    <= i_data[TICK_W-1:0];
                CFG_INC_HIGH:     r_cfg.inc_high     <= i_data[TICK_W-1:0];
                CFG_INC_LOW:      r_cfg.inc_low      <= i_data[TICK_W-1:0];
                CFG_DESEL_HOLD:   r_cfg.desel_hold   <= i_data[TICK_W-1:0];
                CFG_STORE_SELECT: r_cfg.store_select <= i_data[TICK_W-1:0];
                CFG_STORE_HOLD:   r_cfg.store_hold   <= i_data[HOLD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hdl/wdc_core.sv -----
module wdc_core #(
    parameter int TOP_STEP   = 99,
    parameter int TIMER_BITS = 20
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_go,
    input  logic [wdc_pkg::FUNC_W-1:0]        i_func,
    input  logic [wdc_pkg::AMOUNT_W-1:0]      i_amount,
    input  wdc_pkg::t_cfg                     i_cfg,
    output wdc_pkg::t_pins                    o_pins,
    output logic [$clog2(TOP_STEP+1)-1:0]     o_wiper
);
    import wdc_pkg::*;

    localparam int WIPER_W = $clog2(TOP_STEP + 1);
    localparam logic [WIPER_W-1:0] TOP_W = WIPER_W'(TOP_STEP);
    localparam logic [32:0] TMAX = (33'd1 << TIMER_BITS) - 33'd1;

    typedef struct packed {
        logic [PHASE_W-1:0]    phase;
        logic [TIMER_BITS-1:0] timer;
        logic [WIPER_W-1:0]    wiper;
        logic [WIPER_W-1:0]    steps;
        logic                  dir_up;
        logic                  cs;
        logic                  ud;
        logic                  inc;
        logic                  homing;
    } t_state;

    function automatic logic [TIMER_BITS-1:0] f_load(input logic [HOLD_W-1:0] v);
        if (33'(v) > TMAX) begin
            f_load = TIMER_BITS'(TMAX);
        end else begin
            f_load = TIMER_BITS'(v);
        end
    endfunction

    function automatic logic [WIPER_W-1:0] f_move(input logic [WIPER_W-1:0] w,
                                                 input logic [WIPER_W-1:0] k,
                                                 input logic up);
        logic [WIPER_W:0] sum;
        sum = {1'b0, w} + {1'b0, k};
        if (up) begin
            f_move = (sum > {1'b0, TOP_W}) ? TOP_W : sum[WIPER_W-1:0];
        end else begin
            f_move = (k > w) ? '0 : w - k;
        end
    endfunction

    function automatic t_state f_advance(input t_state s, input t_cfg c);
        t_state n;
        logic [WIPER_W-1:0] rem;
        n   = s;
        rem = (s.steps != '0) ? s.steps - WIPER_W'(1) : '0;
        unique case (s.phase)
            PH_DIR: begin
                n.cs    = 1'b0;
                n.inc   = 1'b1;
                n.phase = PH_IHIGH;
                n.timer = f_load(HOLD_W'(c.inc_high));
            end
            PH_IHIGH: begin
                n.inc   = 1'b0;
                n.wiper = f_move(s.wiper, WIPER_W'(1), s.dir_up);
                n.phase = PH_ILOW;
                n.timer = f_load(HOLD_W'(c.inc_low));
            end
            PH_ILOW: begin
                if (rem != '0 && !(c.inc_high == '0 && c.inc_low == '0)) begin
                    n.steps = rem;
                    n.inc   = 1'b1;
                    n.phase = PH_IHIGH;
                    n.timer = f_load(HOLD_W'(c.inc_high));
                end else begin
                    // last pulse, or zero-length pulses: all remaining pulses land at once
                    n.wiper = f_move(s.wiper, rem, s.dir_up);
                    n.steps = '0;
                    n.phase = PH_TAIL;
                    n.timer = f_load(HOLD_W'(c.inc_low));
                end
            end
            PH_TAIL: begin
                n.cs    = 1'b1;
                n.phase = PH_DESEL;
                n.timer = f_load(HOLD_W'(c.desel_hold));
            end
            PH_DESEL: begin
                n.inc   = 1'b1;
                n.phase = PH_FINAL;
                n.timer = f_load(HOLD_W'(c.inc_high));
            end
            PH_SSEL: begin
                n.cs    = 1'b1;
                n.phase = PH_SHOLD;
                n.timer = f_load(c.store_hold);
            end
            default: begin
                if (s.phase == PH_FINAL && s.homing) begin
                    n.wiper = '0;
                end
                n.homing = 1'b0;
                n.phase  = PH_IDLE;
                n.timer  = '0;
            end
        endcase
        f_advance = n;
    endfunction

    function automatic t_state f_start(input t_state s, input logic [WIPER_W-1:0] k,
                                       input logic up, input t_cfg c);
        t_state n;
        n = s;
        if (k != '0) begin
            n.steps  = k;
            n.dir_up = up;
            n.ud     = up;
            n.phase  = PH_DIR;
            n.timer  = f_load(HOLD_W'(c.dir_setup));
        end
        f_start = n;
    endfunction

    t_state             r_st;
    t_state             s_cmd;
    t_state             n_st;
    t_pins              r_pins;
    logic [WIPER_W-1:0] r_wiper;
    logic [WIPER_W-1:0] tgt;
    logic [WIPER_W-1:0] room;
    logic [WIPER_W-1:0] up_cnt;
    logic [WIPER_W-1:0] dn_cnt;
    logic               busy;
    logic               reject;

    always_comb begin
        busy   = (r_st.phase != PH_IDLE);
        tgt    = (i_amount > AMOUNT_W'(TOP_STEP)) ? TOP_W : WIPER_W'(i_amount);
        room   = (r_st.wiper >= TOP_W) ? '0 : TOP_W - r_st.wiper;
        up_cnt = (i_amount > AMOUNT_W'(room)) ? room : WIPER_W'(i_amount);
        dn_cnt = (i_amount > AMOUNT_W'(r_st.wiper)) ? r_st.wiper : WIPER_W'(i_amount);
        reject = 1'b0;
        s_cmd  = r_st;
        if (i_func == FN_TICK) begin
            if (busy && r_st.timer != '0) begin
                s_cmd.timer = r_st.timer - TIMER_BITS'(1);
            end
        end else if (i_func != FN_NOP) begin
            if (busy) begin
                reject = 1'b1;
            end else begin
                unique case (i_func)
                    FN_SET: begin
                        if (tgt > r_st.wiper) begin
                            s_cmd = f_start(r_st, tgt - r_st.wiper, 1'b1, i_cfg);
                        end else if (tgt < r_st.wiper) begin
                            s_cmd = f_start(r_st, r_st.wiper - tgt, 1'b0, i_cfg);
                        end
                    end
                    FN_UP:   s_cmd = f_start(r_st, up_cnt, 1'b1, i_cfg);
                    FN_DOWN: s_cmd = f_start(r_st, dn_cnt, 1'b0, i_cfg);
                    FN_STORE: begin
                        s_cmd.cs    = 1'b0;
                        s_cmd.inc   = 1'b1;
                        s_cmd.phase = PH_SSEL;
                        s_cmd.timer = f_load(HOLD_W'(i_cfg.store_select));
                    end
                    FN_PRESET: s_cmd.wiper = tgt;
                    FN_HOME: begin
                        s_cmd.homing = 1'b1;
                        s_cmd = f_start(s_cmd, TOP_W, 1'b0, i_cfg);
                    end
                    default: begin
                    end
                endcase
            end
        end
        // run through every phase whose time is already used up
        n_st = s_cmd;
        for (int k = 0; k < SETTLE_STEPS; k++) begin
            if (n_st.phase != PH_IDLE && n_st.timer == '0) begin
                n_st = f_advance(n_st, i_cfg);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.phase  <= PH_IDLE;
            r_st.timer  <= '0;
            r_st.wiper  <= '0;
            r_st.steps  <= '0;
            r_st.dir_up <= 1'b1;
            r_st.cs     <= 1'b1;
            r_st.ud     <= 1'b1;
            r_st.inc    <= 1'b1;
            r_st.homing <= 1'b0;
        end else if (i_go) begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_pins.cs       <= n_st.cs;
            r_pins.ud       <= n_st.ud;
            r_pins.inc      <= n_st.inc;
            r_pins.busy     <= (n_st.phase != PH_IDLE);
            r_pins.rejected <= reject;
            r_wiper         <= n_st.wiper;
        end
    end

    assign o_pins  = r_pins;
    assign o_wiper = r_wiper;

endmodule

// ----- hdl/updown_digipot_wiper_controller_top.sv -----
// Wiper controller for a 100-step up/down digital potentiometer: drives chip
// select, up/down and increment and tracks the wiper. Every item (a tick or a
// command) gives one result and the block takes one item per clock cycle while
// the output side is not stalled; an item is held in the input register, and
// its result is written to the result register, from which it is offered and
// held until the output side takes it. The rate is set by the update of the
// sequencer state once per item, which also runs through any chain of
// zero-length phases within that update. Pin timing is counted in tick
// items, not clock cycles. Configuration is to be written by the user through
// the plain write port only while no item is in flight; the block itself does
// not enforce this.
module updown_digipot_wiper_controller_top #(
    parameter int TOP_STEP   = 99,
    parameter int TIMER_BITS = 20
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [wdc_pkg::FUNC_W-1:0]        i_func,
    input  logic [wdc_pkg::AMOUNT_W-1:0]      i_amount,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_cs_level,
    output logic                              o_ud_level,
    output logic                              o_inc_level,
    output logic                              o_busy_res,
    output logic [$clog2(TOP_STEP+1)-1:0]     o_wiper_position,
    output logic                              o_rejected,
    input  logic                              i_cfg_we,
    input  logic [wdc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [wdc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import wdc_pkg::*;

    logic                r_in_valid;
    logic                r_out_valid;
    logic [FUNC_W-1:0]   r_func;
    logic [AMOUNT_W-1:0] r_amount;
    logic                adv;
    logic                go;
    t_cfg                cfg;
    t_pins               pins;

    assign adv        = !r_out_valid || i_out_ready;
    assign go         = r_in_valid && adv;
    assign o_in_ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_func   <= i_func;
            r_amount <= i_amount;
        end
    end

    wdc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    wdc_core #(
        .TOP_STEP   (TOP_STEP),
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (go),
        .i_func   (r_func),
        .i_amount (r_amount),
        .i_cfg    (cfg),
        .o_pins   (pins),
        .o_wiper  (o_wiper_position)
    );

    assign o_out_valid = r_out_valid;
    assign o_cs_level  = pins.cs;
    assign o_ud_level  = pins.ud;
    assign o_inc_level = pins.inc;
    assign o_busy_res  = pins.busy;
    assign o_rejected  = pins.rejected;

endmodule

// ----- hdl/wdc_chk.sv -----
module wdc_chk #(
    parameter int TOP_STEP = 99
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic                              o_cs_level,
    input logic                              o_ud_level,
    input logic                              o_inc_level,
    input logic                              o_busy_res,
    input logic [$clog2(TOP_STEP+1)-1:0]     o_wiper_position,
    input logic                              o_rejected
);
    localparam int WIPER_W = $clog2(TOP_STEP + 1);

    // with no sequence running both chip select and increment rest high
    a_idle_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_busy_res) |-> (o_cs_level && o_inc_level))
        else $error("pins not at rest while idle");

    // a command is only turned away while a sequence runs
    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_rejected) |-> o_busy_res)
        else $error("reject without busy");

    a_wiper_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_wiper_position <= WIPER_W'(TOP_STEP)))
        else $error("wiper beyond top step");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_cs_level)
            && $stable(o_ud_level) && $stable(o_inc_level) && $stable(o_busy_res)
            && $stable(o_wiper_position) && $stable(o_rejected)))
        else $error("stalled item changed");

endmodule

bind updown_digipot_wiper_controller_top wdc_chk #(
    .TOP_STEP (TOP_STEP)
) u_wdc_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_cs_level       (o_cs_level),
    .o_ud_level       (o_ud_level),
    .o_inc_level      (o_inc_level),
    .o_busy_res       (o_busy_res),
    .o_wiper_position (o_wiper_position),
    .o_rejected       (o_rejected)
);
